@@ rtl/hsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types, constants and the CRC byte update for the heater status
// frame decoder.
// ----------------------------------------------------------------------------
package hsfd_pkg;

    localparam int FRAME_BYTES = 24;
    localparam int CRC_SPAN    = 19;

    localparam int IDX_W = 5;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    localparam int CAP_N = 11;
    localparam int CAP_W = $clog2(CAP_N);

    // Frame positions of the kept bytes, in capture slot order.
    localparam logic [IDX_W-1:0] CAP_POS [CAP_N] = '{
        5'd6, 5'd7, 5'd9, 5'd10, 5'd12, 5'd13, 5'd14, 5'd15, 5'd19, 5'd20, 5'd22
    };

    localparam logic [CAP_W-1:0] CAP_HEATER  = 4'd0;
    localparam logic [CAP_W-1:0] CAP_POWER   = 4'd1;
    localparam logic [CAP_W-1:0] CAP_VOLT    = 4'd2;
    localparam logic [CAP_W-1:0] CAP_AMBIENT = 4'd3;
    localparam logic [CAP_W-1:0] CAP_CASE    = 4'd4;
    localparam logic [CAP_W-1:0] CAP_SETP    = 4'd5;
    localparam logic [CAP_W-1:0] CAP_MODE    = 4'd6;
    localparam logic [CAP_W-1:0] CAP_PUMP    = 4'd7;
    localparam logic [CAP_W-1:0] CAP_CRC_HI  = 4'd8;
    localparam logic [CAP_W-1:0] CAP_CRC_LO  = 4'd9;
    localparam logic [CAP_W-1:0] CAP_RSSI    = 4'd10;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  MODE_AUTO = 8'h32;
    localparam logic signed [8:0] RSSI_OFFSET = 9'sd74;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int OUT_DATA_W = 72;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_LEN_ERR = 2'd2
    } t_status;

    // One tagged byte between the front and the back.
    typedef struct packed {
        logic [IDX_W-1:0] pos;
        logic             last;
        logic [7:0]       data;
    } t_item;

    typedef struct packed {
        logic [8:0] rssi_dbm;
        logic [7:0] pump_freq_tenths;
        logic       auto_mode;
        logic [7:0] setpoint;
        logic [7:0] case_temp;
        logic [7:0] ambient_temp;
        logic [7:0] voltage_tenths;
        logic [7:0] power_level;
        logic [7:0] heater_state;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage

@@ rtl/hsfd_front.sv @@
// ----------------------------------------------------------------------------
// hsfd_front
// Accepts frame bytes and tags each with its position in the frame.
// ----------------------------------------------------------------------------
module hsfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data,
    input  logic          i_last,
    input  logic          i_q_ready,
    output logic          o_push,
    output hsfd_pkg::t_item o_item
);
    import hsfd_pkg::*;

    logic [IDX_W-1:0] r_byte_index;
    logic [IDX_W-1:0] n_byte_index;

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    always_comb begin
        o_item.pos  = r_byte_index;
        o_item.last = i_last;
        o_item.data = i_data;
    end

    // The count saturates so that an overlong frame still ends in a length error.
    always_comb begin
        n_byte_index = r_byte_index;
        if (o_push) begin
            if (i_last) begin
                n_byte_index = '0;
            end else if (r_byte_index != IDX_MAX) begin
                n_byte_index = r_byte_index + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
        end else begin
            r_byte_index <= n_byte_index;
        end
    end

    a_index_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_last) |=> (r_byte_index == '0))
        else $error("byte index did not restart after the last byte");

endmodule

@@ rtl/hsfd_fifo.sv @@
// ----------------------------------------------------------------------------
// hsfd_fifo
// Short queue of tagged bytes between the front and the back.
// ----------------------------------------------------------------------------
module hsfd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hsfd_pkg::t_item i_item,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_pop,
    output hsfd_pkg::t_item o_item
);
    import hsfd_pkg::*;

    t_item r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               do_pop;

    assign o_ready = (r_count != FIFO_DEPTH[FIFO_AW:0]);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_ready))
        else $error("push into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_DEPTH[FIFO_AW:0])
        else $error("queue count beyond depth");

endmodule

@@ rtl/hsfd_back.sv @@
// ----------------------------------------------------------------------------
// hsfd_back
// Runs the CRC, keeps the status bytes and registers one result per frame.
// ----------------------------------------------------------------------------
module hsfd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  hsfd_pkg::t_item                i_item,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output hsfd_pkg::t_status              o_status,
    output hsfd_pkg::t_result              o_result
);
    import hsfd_pkg::*;

    logic [15:0] r_crc;
    logic [7:0]  r_cap [CAP_N];
    logic        r_out_valid;
    t_status     r_status;
    t_result     r_result;

    logic        out_free;
    logic        finish;
    t_status     n_status;
    t_result     n_result;
    logic [15:0] expect_crc;
    logic signed [7:0] rssi_raw;
    logic signed [8:0] rssi_half;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = i_valid && (!i_item.last || out_free);
    assign finish   = o_pop && i_item.last;

    // A valid frame ends past every kept byte and the CRC span, so the
    // result depends only on what is already stored.
    assign expect_crc = {r_cap[CAP_CRC_HI], r_cap[CAP_CRC_LO]};
    assign rssi_raw   = $signed(r_cap[CAP_RSSI]);
    // Halve toward zero: add one to negative values before the shift.
    assign rssi_half  = $signed({rssi_raw[7], rssi_raw} + {8'd0, rssi_raw[7]}) >>> 1;

    always_comb begin
        n_result = '0;
        if (i_item.pos != IDX_W'(FRAME_BYTES - 1)) begin
            n_status = ST_LEN_ERR;
        end else if (r_crc != expect_crc) begin
            n_status = ST_CRC_ERR;
        end else begin
            n_status                  = ST_OK;
            n_result.heater_state     = r_cap[CAP_HEATER];
            n_result.power_level      = r_cap[CAP_POWER];
            n_result.voltage_tenths   = r_cap[CAP_VOLT];
            n_result.ambient_temp     = r_cap[CAP_AMBIENT];
            n_result.case_temp        = r_cap[CAP_CASE];
            n_result.setpoint         = r_cap[CAP_SETP];
            n_result.auto_mode        = (r_cap[CAP_MODE] == MODE_AUTO);
            n_result.pump_freq_tenths = r_cap[CAP_PUMP];
            n_result.rssi_dbm         = rssi_half - RSSI_OFFSET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (o_pop) begin
            if (i_item.last) begin
                r_crc <= CRC_INIT;
            end else if (i_item.pos < IDX_W'(CRC_SPAN)) begin
                r_crc <= crc_byte(r_crc, i_item.data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int j = 0; j < CAP_N; j++) begin
                if (i_item.pos == CAP_POS[j]) begin
                    r_cap[j] <= i_item.data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_status <= n_status;
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_result = r_result;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_result == '0))
        else $error("error result carries data");

endmodule

@@ rtl/heater_status_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// heater_status_frame_decoder
// Decodes received heater status frames into one checked result per frame.
// ----------------------------------------------------------------------------
// Frame bytes enter one per request, with tlast on the final byte, and a new
// byte is taken every cycle while the queue has room. Each byte is tagged with
// its position, passes a four-entry queue and is folded into a CRC-16/MODBUS
// over bytes 0 to 18 by a one-byte-per-cycle update. A result is registered
// as the final byte leaves the queue and may wait there while further bytes
// keep flowing in; only a second frame end meeting an unread result holds the
// queue. tuser carries the status (0 valid, 1 CRC mismatch, 2 length not 24);
// on either error every data field reads zero.
module heater_status_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] heater_state, [15:8] power_level, [23:16] voltage_tenths,
    // [31:24] ambient_temp, [39:32] case_temp, [47:40] setpoint,
    // [48] auto_mode, [56:49] pump_freq_tenths, [65:57] rssi_dbm, rest zero
    output logic [hsfd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);
    import hsfd_pkg::*;

    logic    q_ready;
    logic    push;
    t_item   front_item;
    logic    q_valid;
    logic    pop;
    t_item   q_item;
    t_status status;
    t_result result;

    hsfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_item    (front_item)
    );

    hsfd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (q_item)
    );

    hsfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_status (status),
        .o_result (result)
    );

    assign o_m_axis_tdata = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, result};
    assign o_m_axis_tuser = status;

endmodule
